### sv/gld_pkg.sv
// Shared types and constants of the GIF LZW pixel decoder.
// No dependencies; the decoder modules and the testbench import it.
package gld_pkg;

    localparam int CODE_W   = 12;  // widest LZW code the format allows
    localparam int FREE_W   = 13;  // next-free counter, holds 4096
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_PULL    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_PIXEL   = 3'd0,
        ST_MORE    = 3'd1,
        ST_END     = 3'd2,
        ST_CORRUPT = 3'd3,
        ST_TAKEN   = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CFG_MIN_BITS  = 3'd0,
        CFG_COLOR     = 3'd1,
        CFG_WIDTH     = 3'd2,
        CFG_HEIGHT    = 3'd3,
        CFG_INTERLACE = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FIN_RUN = 2'd0,
        FIN_END = 2'd1,
        FIN_BAD = 2'd2
    } t_fin;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_FETCH,
        S_FBYTE,
        S_DECODE,
        S_WALK,
        S_WREAD
    } t_state;

    typedef struct packed {
        logic advance;
        logic restart;
    } t_pos_ctl;

endpackage

### sv/gld_in_if.sv
// Input channel of the decoder: command word with optional raster byte.
// Depends on nothing.
interface gld_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] raster_byte;

    modport source (output valid, output cmd, output raster_byte, input ready);
    modport sink   (input valid, input cmd, input raster_byte, output ready);
endinterface

### sv/gld_out_if.sv
// Output channel of the decoder: status word with pixel and position.
// Depends on nothing.
interface gld_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  pixel_index;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic        in_frame;

    modport source (output valid, output status, output pixel_index, output pixel_x,
                    output pixel_y, output in_frame, input ready);
    modport sink   (input valid, input status, input pixel_index, input pixel_x,
                    input pixel_y, input in_frame, output ready);
endinterface

### sv/gld_dict.sv
// LZW string table: prefix and suffix memories, one write and one read port.
// Depends on gld_pkg.
module gld_dict #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_waddr,
    input  logic [gld_pkg::CODE_W-1:0]       i_wprefix,
    input  logic [7:0]                       i_wsuffix,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_raddr,
    output logic [gld_pkg::CODE_W-1:0]       o_rprefix,
    output logic [7:0]                       o_rsuffix
);
    import gld_pkg::*;

    logic [CODE_W-1:0] prefix_mem [TABLE_ENTRIES];
    logic [7:0]        suffix_mem [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            prefix_mem[i_waddr] <= i_wprefix;
            suffix_mem[i_waddr] <= i_wsuffix;
        end
        o_rprefix <= prefix_mem[i_raddr];
        o_rsuffix <= suffix_mem[i_raddr];
    end
endmodule

### sv/gld_stack.sv
// Character stack memory for the chain walk, registered read.
// Depends on gld_pkg.
module gld_stack #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_waddr,
    input  logic [7:0]                     i_wdata,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_raddr,
    output logic [7:0]                     o_rdata
);
    import gld_pkg::*;

    logic [7:0] stack_mem [STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            stack_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= stack_mem[i_raddr];
    end
endmodule

### sv/gld_pos.sv
// Pixel position tracker: column, row and interlace pass.
// Depends on gld_pkg.
module gld_pos (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gld_pkg::t_pos_ctl i_ctl,
    input  logic [15:0]       i_width,
    input  logic [15:0]       i_height,
    input  logic              i_ilace,
    output logic [15:0]       o_col,
    output logic [15:0]       o_row,
    output logic              o_in_frame
);
    import gld_pkg::*;

    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [1:0]  r_pass, n_pass;
    logic [15:0] col1;
    logic [16:0] row_sum;
    logic [15:0] row_sat;
    logic [3:0]  step;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_pass = r_pass;
        col1   = r_col + 16'd1;
        case (r_pass)
            2'd0, 2'd1: step = 4'd8;
            2'd2:       step = 4'd4;
            default:    step = 4'd2;
        endcase
        if (!i_ilace) begin
            step = 4'd1;
        end
        row_sum = {1'b0, r_row} + 17'(step);
        row_sat = row_sum[16] ? 16'hFFFF : row_sum[15:0];
        if (i_ctl.restart) begin
            n_col  = '0;
            n_row  = '0;
            n_pass = '0;
        end else if (i_ctl.advance) begin
            if (col1 < i_width) begin
                n_col = col1;
            end else begin
                n_col = '0;
                n_row = row_sat;
                // leave the pass once the row runs past the image
                if (i_ilace && r_pass != 2'd3 && row_sat >= i_height) begin
                    n_pass = r_pass + 2'd1;
                    case (r_pass)
                        2'd0:    n_row = 16'd4;
                        2'd1:    n_row = 16'd2;
                        default: n_row = 16'd1;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pass <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pass <= n_pass;
        end
    end

    assign o_col      = r_col;
    assign o_row      = r_row;
    assign o_in_frame = r_row < i_height;
endmodule

### sv/gif_lzw_pixel_decoder.sv
// Top level of the GIF LZW pixel decoder: sequencer, byte queue, bit buffer.
// Depends on gld_pkg, gld_in_if, gld_out_if, gld_dict, gld_stack, gld_pos.
//
//  Channel   Dir  Handshake       Word
//  i_in      in   valid/ready     cmd, raster_byte
//  o_out     out  valid/ready     status, pixel_index, pixel_x, pixel_y, in_frame
//  i_cfg_*   in   write enable    register index, data
//
// A push, restart or unused command answers in the cycle after acceptance.
// A pull that pops a stacked pixel goes through S_POP; a pull that decodes a
// code goes through S_FETCH and S_FBYTE per byte gathered, S_DECODE, and S_WALK
// and S_WREAD per link of the chain, each link a registered string table read.
// Reset is synchronous, active low, and clears all control state; the string
// table and stack memories are not cleared. The input is taken only while the
// sequencer is idle and the result register is empty or being drained.
module gif_lzw_pixel_decoder #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int STACK_DEPTH   = 1024,
    parameter int MAX_CODE_BITS = 12,
    parameter int QUEUE_BYTES   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    gld_in_if.sink                           i_in,
    gld_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [gld_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gld_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    import gld_pkg::*;

    localparam int TA_W  = $clog2(TABLE_ENTRIES);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int SC_W  = $clog2(STACK_DEPTH + 1);
    localparam int QA_W  = $clog2(QUEUE_BYTES);
    localparam int QF_W  = $clog2(QUEUE_BYTES + 1);
    localparam int ACC_W = MAX_CODE_BITS + 8;   // spare code bits plus one byte
    localparam int BH_W  = $clog2(ACC_W + 1);

    // configuration
    logic [3:0]  r_min, r_cbits;
    logic [15:0] r_width, r_height;
    logic        r_ilace;

    // sequencer and decode state
    t_state              r_state, n_state;
    logic [QA_W-1:0]     r_qhead, n_qhead, r_qtail, n_qtail;
    logic [QF_W-1:0]     r_qfill, n_qfill;
    logic [7:0]          q_mem [QUEUE_BYTES];
    logic [7:0]          r_qdata;
    logic                q_we;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [BH_W-1:0]     r_bits, n_bits;
    logic [3:0]          r_cw, n_cw;
    logic [FREE_W-1:0]   r_nf, n_nf;
    logic [CODE_W-1:0]   r_old, n_old, r_code, n_code, r_cur, n_cur;
    logic [7:0]          r_last, n_last;
    t_fin                r_fin, n_fin;
    logic                r_clrp, n_clrp;
    logic [SC_W-1:0]     r_cnt, n_cnt, r_scnt, n_scnt, scnt_m1;

    // result register
    logic        r_ovalid, n_ovalid;
    t_status     r_ostatus, n_ostatus;
    logic [7:0]  r_oidx, n_oidx;
    logic [15:0] r_ox, n_ox, r_oy, n_oy;
    logic        r_oin, n_oin;

    // memory ports and position unit
    logic              d_we;
    logic [CODE_W-1:0] d_rprefix;
    logic [7:0]        d_rsuffix, d_wsuffix;
    logic              s_we;
    logic [SA_W-1:0]   s_waddr;
    logic [7:0]        s_wdata, s_rdata;
    t_pos_ctl          pos_ctl;
    logic [15:0]       pos_col, pos_row;
    logic              pos_in;

    // derived decode constants
    logic [3:0]        eff_min;
    logic [3:0]        eff_cbits;
    logic [8:0]        clr_code;
    logic [7:0]        lit_mask;
    logic [ACC_W-1:0]  code_mask;
    logic [FREE_W-1:0] nf_inc;
    logic              take;

    assign eff_min   = (r_min < 4'd2) ? 4'd2 : ((r_min > 4'd8) ? 4'd8 : r_min);
    assign eff_cbits = (r_cbits > 4'd8) ? 4'd8 : r_cbits;
    assign clr_code  = 9'd1 << eff_min;
    assign lit_mask  = 8'((9'd1 << eff_cbits) - 9'd1);
    assign code_mask = (ACC_W'(1) << r_cw) - ACC_W'(1);
    assign scnt_m1   = r_scnt - SC_W'(1);
    assign nf_inc    = r_nf + FREE_W'(1);

    assign take        = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE) && (!r_ovalid || o_out.ready);

    always_comb begin
        n_state   = r_state;
        n_qhead   = r_qhead;
        n_qtail   = r_qtail;
        n_qfill   = r_qfill;
        n_acc     = r_acc;
        n_bits    = r_bits;
        n_cw      = r_cw;
        n_nf      = r_nf;
        n_old     = r_old;
        n_code    = r_code;
        n_cur     = r_cur;
        n_last    = r_last;
        n_fin     = r_fin;
        n_clrp    = r_clrp;
        n_cnt     = r_cnt;
        n_scnt    = r_scnt;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_ostatus = r_ostatus;
        n_oidx    = r_oidx;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_oin     = r_oin;
        q_we      = 1'b0;
        d_we      = 1'b0;
        d_wsuffix = '0;
        s_we      = 1'b0;
        s_waddr   = r_cnt[SA_W-1:0];
        s_wdata   = d_rsuffix;
        pos_ctl   = '0;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    // status-only answer unless overwritten below
                    n_ovalid  = 1'b1;
                    n_ostatus = ST_MORE;
                    n_oidx    = '0;
                    n_ox      = '0;
                    n_oy      = '0;
                    n_oin     = 1'b0;
                    case (t_cmd'(i_in.cmd))
                        CMD_PUSH: begin
                            if (32'(r_qfill) >= QUEUE_BYTES) begin
                                n_ostatus = ST_FULL;
                            end else begin
                                q_we      = 1'b1;
                                n_qfill   = r_qfill + QF_W'(1);
                                n_qtail   = (32'(r_qtail) == QUEUE_BYTES - 1)
                                            ? '0 : r_qtail + QA_W'(1);
                                n_ostatus = ST_TAKEN;
                            end
                        end
                        CMD_PULL: begin
                            if (r_fin == FIN_END) begin
                                n_ostatus = ST_END;
                            end else if (r_fin != FIN_RUN) begin
                                n_ostatus = ST_CORRUPT;
                            end else if (r_scnt != '0) begin
                                n_ovalid = 1'b0;
                                n_state  = S_POP;
                            end else begin
                                n_ovalid = 1'b0;
                                n_state  = S_FETCH;
                            end
                        end
                        CMD_RESTART: begin
                            n_qhead         = '0;
                            n_qtail         = '0;
                            n_qfill         = '0;
                            n_acc           = '0;
                            n_bits          = '0;
                            n_cw            = eff_min + 4'd1;
                            n_nf            = FREE_W'(clr_code) + FREE_W'(2);
                            n_old           = '0;
                            n_last          = '0;
                            n_fin           = FIN_RUN;
                            n_clrp          = 1'b0;
                            n_scnt          = '0;
                            pos_ctl.restart = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_POP: begin
                // stack read of the top entry was issued at acceptance
                n_scnt          = scnt_m1;
                n_ovalid        = 1'b1;
                n_ostatus       = ST_PIXEL;
                n_oidx          = s_rdata;
                n_ox            = pos_col;
                n_oy            = pos_row;
                n_oin           = pos_in;
                pos_ctl.advance = 1'b1;
                n_state         = S_IDLE;
            end

            S_FETCH: begin
                if (r_bits < BH_W'(r_cw)) begin
                    if (r_qfill != '0) begin
                        n_state = S_FBYTE;
                    end else begin
                        n_ovalid  = 1'b1;
                        n_ostatus = ST_MORE;
                        n_oidx    = '0;
                        n_ox      = '0;
                        n_oy      = '0;
                        n_oin     = 1'b0;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_code  = CODE_W'(r_acc & code_mask);
                    n_acc   = r_acc >> r_cw;
                    n_bits  = r_bits - BH_W'(r_cw);
                    n_state = S_DECODE;
                end
            end

            S_FBYTE: begin
                // append the head byte above the bits already held
                n_acc   = r_acc | (ACC_W'(r_qdata) << r_bits);
                n_bits  = r_bits + BH_W'(8);
                n_qfill = r_qfill - QF_W'(1);
                n_qhead = (32'(r_qhead) == QUEUE_BYTES - 1) ? '0 : r_qhead + QA_W'(1);
                n_state = S_FETCH;
            end

            S_DECODE: begin
                if (r_code == CODE_W'(clr_code) + CODE_W'(1)) begin
                    n_fin     = FIN_END;
                    n_ovalid  = 1'b1;
                    n_ostatus = ST_END;
                    n_oidx    = '0;
                    n_ox      = '0;
                    n_oy      = '0;
                    n_oin     = 1'b0;
                    n_state   = S_IDLE;
                end else if (r_code == CODE_W'(clr_code)) begin
                    n_cw    = eff_min + 4'd1;
                    n_nf    = FREE_W'(clr_code) + FREE_W'(2);
                    n_clrp  = 1'b1;
                    n_state = S_FETCH;
                end else if (r_clrp) begin
                    n_clrp          = 1'b0;
                    n_old           = r_code;
                    n_last          = r_code[7:0] & lit_mask;
                    n_ovalid        = 1'b1;
                    n_ostatus       = ST_PIXEL;
                    n_oidx          = r_code[7:0] & lit_mask;
                    n_ox            = pos_col;
                    n_oy            = pos_row;
                    n_oin           = pos_in;
                    pos_ctl.advance = 1'b1;
                    n_state         = S_IDLE;
                end else if (FREE_W'(r_code) >= r_nf) begin
                    // code not yet in the table: old string plus its first char
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = r_last;
                    n_cur   = r_old;
                    n_cnt   = SC_W'(1);
                    n_state = S_WALK;
                end else begin
                    n_cur   = r_code;
                    n_cnt   = '0;
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                if (r_cur > CODE_W'(lit_mask)) begin
                    if (32'(r_cnt) >= STACK_DEPTH || 32'(r_cur) >= TABLE_ENTRIES) begin
                        n_fin     = FIN_BAD;
                        n_scnt    = '0;
                        n_ovalid  = 1'b1;
                        n_ostatus = ST_CORRUPT;
                        n_oidx    = '0;
                        n_ox      = '0;
                        n_oy      = '0;
                        n_oin     = 1'b0;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_WREAD;
                    end
                end else begin
                    // chain root reached: add the new string if the table has room, emit its first char
                    n_last = r_cur[7:0] & lit_mask;
                    n_scnt = r_cnt;
                    if (r_nf < FREE_W'(TABLE_ENTRIES)) begin
                        d_we      = 1'b1;
                        d_wsuffix = r_cur[7:0] & lit_mask;
                        n_nf      = nf_inc;
                    end
                    n_old = r_code;
                    if (n_nf >= (FREE_W'(1) << r_cw) && r_cw < 4'(MAX_CODE_BITS)) begin
                        n_cw = r_cw + 4'd1;
                    end
                    n_ovalid        = 1'b1;
                    n_ostatus       = ST_PIXEL;
                    n_oidx          = r_cur[7:0] & lit_mask;
                    n_ox            = pos_col;
                    n_oy            = pos_row;
                    n_oin           = pos_in;
                    pos_ctl.advance = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            S_WREAD: begin
                // one link of the chain: push suffix, follow prefix
                s_we    = 1'b1;
                s_waddr = r_cnt[SA_W-1:0];
                s_wdata = d_rsuffix;
                n_cnt   = r_cnt + SC_W'(1);
                n_cur   = d_rprefix;
                n_state = S_WALK;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_min    <= 4'd8;
            r_cbits  <= 4'd8;
            r_width  <= 16'd1;
            r_height <= 16'd1;
            r_ilace  <= 1'b0;
            r_qhead  <= '0;
            r_qtail  <= '0;
            r_qfill  <= '0;
            r_acc    <= '0;
            r_bits   <= '0;
            r_cw     <= 4'd9;
            r_nf     <= FREE_W'(258);
            r_old    <= '0;
            r_last   <= '0;
            r_fin    <= FIN_RUN;
            r_clrp   <= 1'b0;
            r_cnt    <= '0;
            r_scnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_qhead  <= n_qhead;
            r_qtail  <= n_qtail;
            r_qfill  <= n_qfill;
            r_acc    <= n_acc;
            r_bits   <= n_bits;
            r_cw     <= n_cw;
            r_nf     <= n_nf;
            r_old    <= n_old;
            r_last   <= n_last;
            r_fin    <= n_fin;
            r_clrp   <= n_clrp;
            r_cnt    <= n_cnt;
            r_scnt   <= n_scnt;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MIN_BITS:  r_min    <= i_cfg_data[3:0];
                    CFG_COLOR:     r_cbits  <= i_cfg_data[3:0];
                    CFG_WIDTH:     r_width  <= i_cfg_data;
                    CFG_HEIGHT:    r_height <= i_cfg_data;
                    CFG_INTERLACE: r_ilace  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_cur     <= n_cur;
        r_ostatus <= n_ostatus;
        r_oidx    <= n_oidx;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_oin     <= n_oin;
    end

    // byte queue: circular buffer, registered read at the head
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[r_qtail] <= i_in.raster_byte;
        end
        r_qdata <= q_mem[r_qhead];
    end

    gld_dict #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dict (
        .i_clk     (i_clk),
        .i_we      (d_we),
        .i_waddr   (r_nf[TA_W-1:0]),
        .i_wprefix (r_old),
        .i_wsuffix (d_wsuffix),
        .i_raddr   (r_cur[TA_W-1:0]),
        .o_rprefix (d_rprefix),
        .o_rsuffix (d_rsuffix)
    );

    gld_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (scnt_m1[SA_W-1:0]),
        .o_rdata (s_rdata)
    );

    gld_pos u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (pos_ctl),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_ilace    (r_ilace),
        .o_col      (pos_col),
        .o_row      (pos_row),
        .o_in_frame (pos_in)
    );

    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_ostatus;
    assign o_out.pixel_index = r_oidx;
    assign o_out.pixel_x     = r_ox;
    assign o_out.pixel_y     = r_oy;
    assign o_out.in_frame    = r_oin;
endmodule

### dv/tb_gif_lzw_pixel_decoder.sv
// Self-checking testbench of the GIF LZW pixel decoder: directed streams, register
// clamps and random images, checked against an internal decoder model.
// Depends on gld_pkg, gld_in_if, gld_out_if and gif_lzw_pixel_decoder.
`timescale 1ns / 1ps

module tb_gif_lzw_pixel_decoder;
    import gld_pkg::*;

    localparam int TBL_N = 4096;
    localparam int STK_N = 1024;
    localparam int Q_N   = 16;

    // String table as the decoder sees it; known marks entries ever written,
    // since the RTL memories are never cleared.
    typedef struct {
        logic [11:0] prefix [TBL_N];
        logic [7:0]  suffix [TBL_N];
        bit          known  [TBL_N];
        int          nf;
        int          cw;
        int          old;
        int          lastc;
        bit          clr_pend;
    } lzw_t;

    typedef bit [7:0] pix_q_t[$];

    typedef struct packed {
        t_status     st;
        logic [7:0]  idx;
        logic [15:0] x;
        logic [15:0] y;
        logic        inf;
    } pix_res_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    gld_in_if  in_ch ();
    gld_out_if out_ch ();

    gif_lzw_pixel_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow registers, as last written.
    logic [3:0]  cfg_min   = 4'd8;
    logic [3:0]  cfg_color = 4'd8;
    logic [15:0] cfg_w     = 16'd1;
    logic [15:0] cfg_h     = 16'd1;
    logic        cfg_il    = 1'b0;

    // Decoder state of the model.
    lzw_t        dict_st;
    lzw_t        plan_st;      // look-ahead copy used to build legal code streams
    bit [7:0]    queue_bytes[$];
    int unsigned bit_acc;
    int          bits_held;
    pix_q_t      pix_stack;
    logic [15:0] col_pos;
    logic [15:0] row_pos;
    int          pass_num;
    t_fin        fin;

    pix_res_t    answers_due[$];
    t_status     last_st;
    int          fails;
    int          sent_count;
    int          accept_count;
    bit          idle_on;
    int          stall_left;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    function automatic int eff_min();
        if (cfg_min < 2) return 2;
        if (cfg_min > 8) return 8;
        return cfg_min;
    endfunction

    function automatic int lit_mask();
        int c;
        c = (cfg_color > 8) ? 8 : cfg_color;
        return (1 << c) - 1;
    endfunction

    // Process one code against a table; return the string it yields, in pixel order.
    function automatic void lzw_apply(ref lzw_t d, input int code, output bit ended,
                                      output bit bad, output pix_q_t chars);
        int clr;
        int mask;
        int cur;
        int stk[$];
        clr   = 1 << eff_min();
        mask  = lit_mask();
        ended = 1'b0;
        bad   = 1'b0;
        chars = {};
        if (code == clr + 1) begin
            ended = 1'b1;
            return;
        end
        if (code == clr) begin
            d.cw       = eff_min() + 1;
            d.nf       = clr + 2;
            d.clr_pend = 1'b1;
            return;
        end
        // First code after a clear is a plain literal, whatever its value.
        if (d.clr_pend) begin
            d.clr_pend = 1'b0;
            d.old      = code;
            d.lastc    = code & mask;
            chars.push_back(d.lastc);
            return;
        end
        cur = code;
        // Code not yet in the table: old string plus its own first char.
        if (cur >= d.nf) begin
            cur = d.old;
            stk.push_back(d.lastc);
        end
        while (cur > mask) begin
            if (stk.size() >= STK_N || cur >= TBL_N) begin
                bad = 1'b1;
                return;
            end
            stk.push_back(d.suffix[cur]);
            cur = d.prefix[cur];
        end
        d.lastc = cur & mask;
        chars.push_back(d.lastc);
        for (int i = stk.size() - 1; i >= 0; i--)
            chars.push_back(stk[i]);
        if (d.nf < TBL_N) begin
            d.prefix[d.nf] = d.old;
            d.suffix[d.nf] = d.lastc;
            d.known[d.nf]  = 1'b1;
            d.nf++;
        end
        d.old = code;
        if (d.nf >= (1 << d.cw) && d.cw < 12)
            d.cw++;
    endfunction

    function automatic void restart_decoder();
        queue_bytes.delete();
        pix_stack.delete();
        bit_acc           = 0;
        bits_held         = 0;
        dict_st.cw        = eff_min() + 1;
        dict_st.nf        = (1 << eff_min()) + 2;
        dict_st.old       = 0;
        dict_st.lastc     = 0;
        dict_st.clr_pend  = 1'b0;
        col_pos           = '0;
        row_pos           = '0;
        pass_num          = 0;
        fin               = FIN_RUN;
    endfunction

    function automatic pix_res_t status_word(t_status s);
        pix_res_t r;
        r    = '0;
        r.st = s;
        return r;
    endfunction

    function automatic void bump_row(int inc);
        int t;
        t = row_pos + inc;
        row_pos = (t > 65535) ? 16'hFFFF : t[15:0];
    endfunction

    // Emit one pixel at the current position, then step the raster position.
    function automatic pix_res_t emit_pixel(bit [7:0] idx);
        pix_res_t r;
        r.st  = ST_PIXEL;
        r.idx = idx;
        r.x   = col_pos;
        r.y   = row_pos;
        r.inf = row_pos < cfg_h;
        col_pos = col_pos + 16'd1;
        if (col_pos >= cfg_w) begin
            col_pos = '0;
            if (!cfg_il) begin
                bump_row(1);
            end else begin
                case (pass_num)
                    0: begin
                        bump_row(8);
                        if (row_pos >= cfg_h) begin pass_num = 1; row_pos = 16'd4; end
                    end
                    1: begin
                        bump_row(8);
                        if (row_pos >= cfg_h) begin pass_num = 2; row_pos = 16'd2; end
                    end
                    2: begin
                        bump_row(4);
                        if (row_pos >= cfg_h) begin pass_num = 3; row_pos = 16'd1; end
                    end
                    default: bump_row(2);
                endcase
            end
        end
        return r;
    endfunction

    function automatic pix_res_t pull_pixel();
        int     code;
        bit     ended;
        bit     bad;
        pix_q_t chars;
        if (fin == FIN_END) return status_word(ST_END);
        if (fin == FIN_BAD) return status_word(ST_CORRUPT);
        if (pix_stack.size() > 0) return emit_pixel(pix_stack.pop_front());
        forever begin
            while (bits_held < dict_st.cw && queue_bytes.size() > 0) begin
                bit_acc   |= 32'(queue_bytes.pop_front()) << bits_held;
                bits_held += 8;
            end
            // Keep gathered bits; the next pull resumes from them.
            if (bits_held < dict_st.cw) return status_word(ST_MORE);
            code       = bit_acc & ((1 << dict_st.cw) - 1);
            bit_acc    = bit_acc >> dict_st.cw;
            bits_held -= dict_st.cw;
            lzw_apply(dict_st, code, ended, bad, chars);
            if (ended) begin
                fin = FIN_END;
                return status_word(ST_END);
            end
            if (bad) begin
                fin = FIN_BAD;
                pix_stack.delete();
                return status_word(ST_CORRUPT);
            end
            if (chars.size() > 0) begin
                pix_stack = chars;
                return emit_pixel(pix_stack.pop_front());
            end
        end
    endfunction

    function automatic pix_res_t decode_word(t_cmd c, bit [7:0] b);
        case (c)
            CMD_PUSH: begin
                if (queue_bytes.size() >= Q_N) return status_word(ST_FULL);
                queue_bytes.push_back(b);
                return status_word(ST_TAKEN);
            end
            CMD_PULL:    return pull_pixel();
            CMD_RESTART: begin
                restart_decoder();
                return status_word(ST_MORE);
            end
            default:     return status_word(ST_MORE);
        endcase
    endfunction

    // Predict at every accepted input word.
    always @(posedge i_clk) begin
        pix_res_t w;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            w = decode_word(t_cmd'(in_ch.cmd), in_ch.raster_byte);
            answers_due.push_back(w);
            last_st = w.st;
            accept_count++;
        end
    end

    // Compare every accepted output word with the oldest prediction.
    always @(posedge i_clk) begin
        pix_res_t got;
        pix_res_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.st  = t_status'(out_ch.status);
            got.idx = out_ch.pixel_index;
            got.x   = out_ch.pixel_x;
            got.y   = out_ch.pixel_y;
            got.inf = out_ch.in_frame;
            if (answers_due.size() == 0) begin
                fails++;
                if (fails <= 40)
                    $display("%0t: unexpected word, expected none, %s=%0d %0d %0d %0d %0d",
                             $time, "got st/idx/x/y/in",
                             got.st, got.idx, got.x, got.y, got.inf);
            end else begin
                want = answers_due.pop_front();
                if (got.st !== want.st || got.idx !== want.idx || got.x !== want.x ||
                    got.y !== want.y || got.inf !== want.inf) begin
                    fails++;
                    if (fails <= 40)
                        $display({"%0t: mismatch, expected st=%0d idx=%0d x=%0d y=%0d in=%0d,",
                                  " got st=%0d idx=%0d x=%0d y=%0d in=%0d"},
                                 $time, want.st, want.idx, want.x, want.y, want.inf,
                                 got.st, got.idx, got.x, got.y, got.inf);
                end
            end
        end
    end

    // Output back-pressure: random stall bursts while idling is on.
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready = 1'b0;
        end else if (idle_on && $urandom_range(7, 0) == 0) begin
            stall_left   = $urandom_range(13, 1) - 1;
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_word(t_cmd c, bit [7:0] b);
        int start_n;
        if (idle_on && $urandom_range(4, 0) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(13, 1)) @(negedge i_clk);
        end
        start_n           = accept_count;
        in_ch.valid       = 1'b1;
        in_ch.cmd         = c;
        in_ch.raster_byte = b;
        // hold the word until the rising edge that takes it has passed
        while (accept_count == start_n) @(negedge i_clk);
        in_ch.valid = 1'b0;
        sent_count++;
    endtask

    task automatic set_reg(t_cfg_idx idx, int val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[15:0];
        case (idx)
            CFG_MIN_BITS:  cfg_min   = val[3:0];
            CFG_COLOR:     cfg_color = val[3:0];
            CFG_WIDTH:     cfg_w     = val[15:0];
            CFG_HEIGHT:    cfg_h     = val[15:0];
            default:       cfg_il    = val[0];
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic set_image(int mn, int clr_bits, int w, int h, int il);
        wait_drained();
        set_reg(CFG_MIN_BITS, mn);
        set_reg(CFG_COLOR, clr_bits);
        set_reg(CFG_WIDTH, w);
        set_reg(CFG_HEIGHT, h);
        set_reg(CFG_INTERLACE, il);
    endtask

    // Choose a code the decoder can take without walking an unwritten entry.
    // Modes: 0 mixed, 1 literals only, 2 always the next free code.
    function automatic int pick_code(int mode);
        int clr;
        int lim;
        int litn;
        int c;
        int r;
        int cur;
        int cnt;
        bit ok;
        clr  = 1 << eff_min();
        lim  = 1 << plan_st.cw;
        litn = (lit_mask() + 1 < lim) ? lit_mask() + 1 : lim;
        if (mode == 2) return plan_st.nf;
        repeat (24) begin
            r = $urandom_range(99, 0);
            if (mode == 1 || plan_st.clr_pend || r < 30)
                c = $urandom_range(litn - 1, 0);
            else if (r < 70 && plan_st.nf > clr + 2)
                c = $urandom_range(((plan_st.nf < lim) ? plan_st.nf : lim) - 1, clr + 2);
            else if (r < 85)
                c = plan_st.nf;
            else if (r < 95)
                c = $urandom_range(lim - 1, 0);
            else
                return clr;
            if (c < lim && c != clr && c != clr + 1) begin
                ok = 1'b1;
                if (!plan_st.clr_pend) begin
                    cur = c;
                    cnt = 0;
                    if (cur >= plan_st.nf) begin
                        cur = plan_st.old;
                        cnt = 1;
                    end
                    // A chain long enough to overflow the stack is legal: it ends corrupt.
                    while (cur > lit_mask() && cnt < STK_N && ok) begin
                        if (!plan_st.known[cur]) ok = 1'b0;
                        cnt++;
                        cur = plan_st.prefix[cur];
                    end
                end
                if (ok) return c;
            end
        end
        return clr;
    endfunction

    // Feed a packed stream, mixing pushes, pulls and unused commands.
    task automatic feed(bit [7:0] bytes[$]);
        int pos;
        int r;
        bit done;
        pos  = 0;
        done = 1'b0;
        while (!done) begin
            r = $urandom_range(99, 0);
            if (pos < bytes.size() && queue_bytes.size() < Q_N &&
                (r < 50 || queue_bytes.size() < 2)) begin
                send_word(CMD_PUSH, bytes[pos]);
                pos++;
            end else if (r < 53) begin
                send_word(CMD_NOP, $urandom_range(255, 0));
            end else begin
                send_word(CMD_PULL, $urandom_range(255, 0));
                if (last_st == ST_END || last_st == ST_CORRUPT ||
                    (last_st == ST_MORE && pos == bytes.size()))
                    done = 1'b1;
            end
        end
        // A finished decoder keeps answering the same way.
        if (last_st == ST_END || last_st == ST_CORRUPT)
            send_word(CMD_PULL, $urandom_range(255, 0));
    endtask

    // Restart, then decode the scripted codes followed by n picked codes.
    task automatic run_image(int script[$], int n, int mode, bit add_end);
        int     code;
        bit     ended;
        bit     bad;
        pix_q_t chars;
        bit     bits[$];
        bit [7:0] bytes[$];
        bit [7:0] b;
        wait_drained();
        send_word(CMD_RESTART, $urandom_range(255, 0));
        wait_drained();
        plan_st = dict_st;
        ended   = 1'b0;
        bad     = 1'b0;
        for (int k = 0; k < script.size() + n && !ended && !bad; k++) begin
            code = (k < script.size()) ? script[k] : pick_code(mode);
            for (int i = 0; i < plan_st.cw; i++)
                bits.push_back(code[i]);
            lzw_apply(plan_st, code, ended, bad, chars);
        end
        if (add_end && !ended && !bad) begin
            code = (1 << eff_min()) + 1;
            for (int i = 0; i < plan_st.cw; i++)
                bits.push_back(code[i]);
        end
        // Drop a trailing partial byte so no padding is ever read as a code.
        while (bits.size() >= 8) begin
            for (int i = 0; i < 8; i++)
                b[i] = bits.pop_front();
            bytes.push_back(b);
        end
        feed(bytes);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_idle_commands();
        send_word(CMD_PULL, 8'h00);
        send_word(CMD_NOP, 8'hFF);
        send_word(CMD_RESTART, 8'h5A);
        send_word(CMD_PULL, 8'hA5);
    endtask

    task automatic test_queue_full();
        for (int i = 0; i < Q_N + 1; i++)
            send_word(CMD_PUSH, (i % 2) ? 8'hFF : 8'h00);
        send_word(CMD_RESTART, 8'h00);
    endtask

    task automatic test_special_streams();
        set_image(2, 2, 3, 2, 0);
        run_image('{4, 4, 1, 6, 6, 2}, 0, 0, 1);    // clear after clear, KwKwK
        run_image('{2, 6, 3, 7}, 0, 0, 1);          // first code not a clear
        run_image('{4, 5}, 0, 0, 0);                // clear then end
        set_image(3, 3, 4, 3, 1);
        run_image('{8, 1, 13}, 0, 0, 1);            // code beyond next free
        set_image(8, 8, 5, 4, 0);
        // Build a self-referencing entry so the chain walk overflows the stack.
        run_image('{256, 259, 0, 256, 258, 0, 258}, 0, 0, 0);
    endtask

    task automatic test_register_clamp();
        set_image(0, 15, 0, 65535, 1);
        run_image('{}, 10, 0, 1);
        set_image(15, 0, 65535, 0, 0);
        run_image('{}, 10, 0, 1);
        set_image(1, 9, 2, 1, 1);
        run_image('{}, 10, 0, 0);
    endtask

    task automatic test_random_images();
        int start;
        int r;
        int mn;
        int cb;
        int w;
        int h;
        start = sent_count;
        while (sent_count < start + 800) begin
            // Drop idling for the last stretch of the run.
            idle_on = (sent_count < start + 640);
            mn = ($urandom_range(9, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(8, 2);
            cb = ($urandom_range(9, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(8, 1);
            r  = $urandom_range(99, 0);
            w  = (r < 8) ? 0 : (r < 16) ? 65535 : $urandom_range(24, 1);
            r  = $urandom_range(99, 0);
            h  = (r < 8) ? 0 : (r < 16) ? 65535 : $urandom_range(24, 1);
            set_image(mn, cb, w, h, $urandom_range(1, 0));
            run_image(($urandom_range(4, 0) == 0) ? '{} : '{1 << eff_min()},
                      $urandom_range(40, 3), 0, $urandom_range(9, 0) < 7);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int guard;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_NOP;
        in_ch.raster_byte = '0;
        fails             = 0;
        sent_count        = 0;
        accept_count      = 0;
        stall_left        = 0;
        idle_on           = 1'b1;
        last_st           = ST_MORE;
        restart_decoder();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_commands();
        test_queue_full();
        test_special_streams();
        test_register_clamp();
        test_random_images();

        // Hold until every predicted word is back, with a bound.
        guard = 0;
        while (answers_due.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        if (answers_due.size() != 0) begin
            fails++;
            $display("%0t: %0d expected words never arrived", $time, answers_due.size());
        end
        repeat (20) @(negedge i_clk);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
